[rtl/wdt_pkg.sv]
// ----------------------------------------------------------------------------
// Word dictionary trainer package
// Shared types, widths, operation and status codes, controller commands and
// the datapath status bundle.
// ----------------------------------------------------------------------------
package wdt_pkg;

   localparam int MAX_ENTRIES    = 512;
   localparam int MAX_WORD_BYTES = 255;
   localparam int ENT_W          = $clog2(MAX_ENTRIES);
   localparam int ENT_CW         = $clog2(MAX_ENTRIES + 1);
   localparam int RUN_W          = $clog2(MAX_WORD_BYTES);
   localparam int RUN_CW         = $clog2(MAX_WORD_BYTES + 1) + 1;
   localparam int WS_DEPTH       = MAX_ENTRIES * MAX_WORD_BYTES;
   localparam int WS_AW          = $clog2(WS_DEPTH);
   localparam int REF_THRESHOLD  = 256;
   localparam int OVERHEAD_BITS  = 8;
   localparam int GAIN_W         = 45;
   localparam int BW_W           = 13;
   localparam int KEPT_W         = 38;

   localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};

   localparam logic [1:0] OP_TEXT   = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_TABLE_FULL = 2'd1;
   localparam logic [1:0] ST_COUNT_OVF  = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX  = 2'd3;

   localparam logic [0:0] CSR_BITS_PER_CHAR = 1'd0;
   localparam logic [0:0] CSR_MIN_WORD_LEN  = 1'd1;

   localparam logic [4:0] CMD_NONE       = 5'd0;
   localparam logic [4:0] CMD_CLEAR      = 5'd1;
   localparam logic [4:0] CMD_APPEND     = 5'd2;
   localparam logic [4:0] CMD_ENT_CLR    = 5'd3;
   localparam logic [4:0] CMD_RD_LEN     = 5'd4;
   localparam logic [4:0] CMD_ENT_INC    = 5'd5;
   localparam logic [4:0] CMD_K_CLR      = 5'd6;
   localparam logic [4:0] CMD_RD_BYTE    = 5'd7;
   localparam logic [4:0] CMD_K_INC      = 5'd8;
   localparam logic [4:0] CMD_SLOT_FOUND = 5'd9;
   localparam logic [4:0] CMD_SET_FULL   = 5'd10;
   localparam logic [4:0] CMD_SLOT_NEW   = 5'd11;
   localparam logic [4:0] CMD_RD_RUN     = 5'd12;
   localparam logic [4:0] CMD_WR_WORD    = 5'd13;
   localparam logic [4:0] CMD_NEW_ENTRY  = 5'd14;
   localparam logic [4:0] CMD_RD_CNT     = 5'd15;
   localparam logic [4:0] CMD_CNT_UPD    = 5'd16;
   localparam logic [4:0] CMD_RUN_CLR    = 5'd17;
   localparam logic [4:0] CMD_FIN_INIT   = 5'd18;
   localparam logic [4:0] CMD_SET_DONE   = 5'd19;
   localparam logic [4:0] CMD_ENT_LOAD   = 5'd20;
   localparam logic [4:0] CMD_RD_ENT     = 5'd21;
   localparam logic [4:0] CMD_GAIN1      = 5'd22;
   localparam logic [4:0] CMD_GAIN2      = 5'd23;
   localparam logic [4:0] CMD_GAIN3      = 5'd24;
   localparam logic [4:0] CMD_REF_WR     = 5'd25;
   localparam logic [4:0] CMD_LOAD_RSP   = 5'd26;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] text_byte;
      logic [8:0] entry_index;
      logic [7:0] char_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [9:0]        entry_total;
      logic [1:0]        ref_width_bytes;
      logic [7:0]        word_length;
      logic [31:0]       occurrence_count;
      logic [GAIN_W-1:0] gain_bits;
      logic              has_ref;
      logic [8:0]        ref_number;
      logic [7:0]        char_value;
   } rsp_type;

   typedef struct packed {
      logic [4:0] code;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       byte_is_word;
      logic       run_open;
      logic       ent_end;
      logic       len_match;
      logic       k_end;
      logic       byte_match;
      logic       table_full;
      logic       idx_oob;
      logic       rsp_busy;
   } dp_status_type;

   function automatic logic is_word_byte(input logic [7:0] c);
      is_word_byte = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
   endfunction

endpackage

[rtl/wdt_ctrl.sv]
// ----------------------------------------------------------------------------
// Word dictionary trainer controller
// Sequences lookups, inserts, the finish walk and entry reads.
// ----------------------------------------------------------------------------
module wdt_ctrl import wdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type st,
   output cmd_type       cmd
);

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_DISPATCH   = 5'd1;
   localparam logic [4:0] S_TEXT       = 5'd2;
   localparam logic [4:0] S_TEXT2      = 5'd3;
   localparam logic [4:0] S_CR_START   = 5'd4;
   localparam logic [4:0] S_CR_LEN     = 5'd5;
   localparam logic [4:0] S_CR_LENCHK  = 5'd6;
   localparam logic [4:0] S_CR_BYTE    = 5'd7;
   localparam logic [4:0] S_CR_BYTECHK = 5'd8;
   localparam logic [4:0] S_INS        = 5'd9;
   localparam logic [4:0] S_INS_RD     = 5'd10;
   localparam logic [4:0] S_INS_WR     = 5'd11;
   localparam logic [4:0] S_INS_NEW    = 5'd12;
   localparam logic [4:0] S_CNT_RD     = 5'd13;
   localparam logic [4:0] S_CNT_UPD    = 5'd14;
   localparam logic [4:0] S_CR_END     = 5'd15;
   localparam logic [4:0] S_FIN_INIT   = 5'd16;
   localparam logic [4:0] S_FIN_LOOP   = 5'd17;
   localparam logic [4:0] S_RD_START   = 5'd18;
   localparam logic [4:0] S_RD_ENT     = 5'd19;
   localparam logic [4:0] S_G1         = 5'd20;
   localparam logic [4:0] S_G2         = 5'd21;
   localparam logic [4:0] S_G3         = 5'd22;
   localparam logic [4:0] S_FIN_WR     = 5'd23;
   localparam logic [4:0] S_RESP       = 5'd24;

   logic [4:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.code = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (st.op)
               OP_TEXT:   state_in = S_TEXT;
               OP_FINISH: state_in = S_CR_START;
               OP_READ:   state_in = S_RD_START;
               default:   state_in = S_IDLE;
            endcase
         end
         S_TEXT: begin
            cmd.code = CMD_CLEAR;
            state_in = S_TEXT2;
         end
         S_TEXT2: begin
            if (st.byte_is_word) begin
               cmd.code = CMD_APPEND;
               state_in = S_IDLE;
            end else begin
               state_in = S_CR_START;
            end
         end
         S_CR_START: begin
            if (st.run_open) begin
               cmd.code = CMD_ENT_CLR;
               state_in = S_CR_LEN;
            end else begin
               state_in = S_CR_END;
            end
         end
         S_CR_LEN: begin
            if (st.ent_end) begin
               state_in = S_INS;
            end else begin
               cmd.code = CMD_RD_LEN;
               state_in = S_CR_LENCHK;
            end
         end
         S_CR_LENCHK: begin
            if (st.len_match) begin
               cmd.code = CMD_K_CLR;
               state_in = S_CR_BYTE;
            end else begin
               cmd.code = CMD_ENT_INC;
               state_in = S_CR_LEN;
            end
         end
         S_CR_BYTE: begin
            if (st.k_end) begin
               cmd.code = CMD_SLOT_FOUND;
               state_in = S_CNT_RD;
            end else begin
               cmd.code = CMD_RD_BYTE;
               state_in = S_CR_BYTECHK;
            end
         end
         S_CR_BYTECHK: begin
            if (st.byte_match) begin
               cmd.code = CMD_K_INC;
               state_in = S_CR_BYTE;
            end else begin
               cmd.code = CMD_ENT_INC;
               state_in = S_CR_LEN;
            end
         end
         S_INS: begin
            if (st.table_full) begin
               cmd.code = CMD_SET_FULL;
               state_in = S_CR_END;
            end else begin
               cmd.code = CMD_SLOT_NEW;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (st.k_end) begin
               state_in = S_INS_NEW;
            end else begin
               cmd.code = CMD_RD_RUN;
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.code = CMD_WR_WORD;
            state_in = S_INS_RD;
         end
         S_INS_NEW: begin
            cmd.code = CMD_NEW_ENTRY;
            state_in = S_CR_END;
         end
         S_CNT_RD: begin
            cmd.code = CMD_RD_CNT;
            state_in = S_CNT_UPD;
         end
         S_CNT_UPD: begin
            cmd.code = CMD_CNT_UPD;
            state_in = S_CR_END;
         end
         S_CR_END: begin
            cmd.code = CMD_RUN_CLR;
            state_in = (st.op == OP_FINISH) ? S_FIN_INIT : S_IDLE;
         end
         S_FIN_INIT: begin
            cmd.code = CMD_FIN_INIT;
            state_in = S_FIN_LOOP;
         end
         S_FIN_LOOP: begin
            if (st.ent_end) begin
               cmd.code = CMD_SET_DONE;
               state_in = S_RESP;
            end else begin
               cmd.code = CMD_RD_ENT;
               state_in = S_G1;
            end
         end
         S_RD_START: begin
            if (st.idx_oob) begin
               state_in = S_RESP;
            end else begin
               cmd.code = CMD_ENT_LOAD;
               state_in = S_RD_ENT;
            end
         end
         S_RD_ENT: begin
            cmd.code = CMD_RD_ENT;
            state_in = S_G1;
         end
         S_G1: begin
            cmd.code = CMD_GAIN1;
            state_in = S_G2;
         end
         S_G2: begin
            cmd.code = CMD_GAIN2;
            state_in = S_G3;
         end
         S_G3: begin
            cmd.code = CMD_GAIN3;
            state_in = (st.op == OP_FINISH) ? S_FIN_WR : S_RESP;
         end
         S_FIN_WR: begin
            cmd.code = CMD_REF_WR;
            state_in = S_FIN_LOOP;
         end
         S_RESP: begin
            if (!st.rsp_busy) begin
               cmd.code = CMD_LOAD_RSP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/wdt_dp.sv]
// ----------------------------------------------------------------------------
// Word dictionary trainer datapath
// Run buffer, word table memories, gain pipeline and the result register.
// ----------------------------------------------------------------------------
module wdt_dp import wdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  logic [0:0]    csr_index,
   input  logic [7:0]    csr_wdata,
   input  cmd_type       cmd,
   output dp_status_type st
);

   // Memories, no reset.
   logic [7:0]  rb_mem  [0:MAX_WORD_BYTES-1];
   logic [7:0]  ws_mem  [0:WS_DEPTH-1];
   logic [7:0]  len_mem [0:MAX_ENTRIES-1];
   logic [31:0] cnt_mem [0:MAX_ENTRIES-1];
   logic [10:0] ref_mem [0:MAX_ENTRIES-1];

   // Control state.
   logic [RUN_CW-1:0] run_len_ff;
   logic              too_long_ff;
   logic [ENT_CW-1:0] stored_ff;
   logic [1:0]        err_ff;
   logic [1:0]        refw_ff;
   logic              done_ff;
   logic [4:0]        bpc_ff;
   logic [7:0]        minlen_ff;
   logic              rsp_valid_ff;

   // Working registers.
   req_type           req_ff;
   logic [ENT_CW-1:0] ent_ff;
   logic [RUN_W-1:0]  k_ff;
   logic [ENT_W-1:0]  slot_ff;
   logic [9:0]        next_ff;
   logic [7:0]        len_rd_ff;
   logic [31:0]       cnt_rd_ff;
   logic [10:0]       ref_rd_ff;
   logic [7:0]        ws_rd_ff;
   logic [7:0]        rb_rd_ff;
   logic [BW_W-1:0]   bw_ff;
   logic [GAIN_W-1:0] rep_ff;
   logic [KEPT_W-1:0] kept_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic              gain_pos_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic [WS_AW-1:0]  ws_raddr, ws_waddr;
   logic [ENT_W-1:0]  ent_idx;
   logic [GAIN_W:0]   diff;
   logic              qualify;
   logic              oob;

   assign ent_idx  = ent_ff[ENT_W-1:0];
   assign ws_raddr = WS_AW'(ent_idx) * WS_AW'(MAX_WORD_BYTES) + WS_AW'(k_ff);
   assign ws_waddr = WS_AW'(slot_ff) * WS_AW'(MAX_WORD_BYTES) + WS_AW'(k_ff);
   assign diff     = {1'b0, rep_ff} - {{(GAIN_W + 1 - KEPT_W){1'b0}}, kept_ff};
   assign qualify  = (err_ff == ST_OK) && (len_rd_ff >= minlen_ff) && gain_pos_ff;
   assign oob      = ({1'b0, req_ff.entry_index} >= stored_ff);

   assign st.op           = req_ff.operation;
   assign st.byte_is_word = is_word_byte(req_ff.text_byte);
   assign st.run_open     = (run_len_ff != '0) && !too_long_ff && (err_ff == ST_OK);
   assign st.ent_end      = (ent_ff == stored_ff);
   assign st.len_match    = (RUN_CW'(len_rd_ff) == run_len_ff);
   assign st.k_end        = (RUN_CW'(k_ff) == run_len_ff);
   assign st.byte_match   = (ws_rd_ff == rb_rd_ff);
   assign st.table_full   = (stored_ff >= ENT_CW'(MAX_ENTRIES));
   assign st.idx_oob      = oob;
   assign st.rsp_busy     = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Result fields for the word in work; entry fields stay zero unless a read
   // hits a stored entry.
   always_comb begin
      rsp_in                 = '0;
      rsp_in.status          = err_ff;
      rsp_in.entry_total     = 10'(stored_ff);
      rsp_in.ref_width_bytes = refw_ff;
      if (req_ff.operation == OP_READ) begin
         if (oob) begin
            rsp_in.status = ST_BAD_INDEX;
         end else begin
            rsp_in.word_length      = len_rd_ff;
            rsp_in.occurrence_count = cnt_rd_ff;
            rsp_in.gain_bits        = gain_ff;
            rsp_in.has_ref          = ref_rd_ff[10];
            rsp_in.ref_number       = ref_rd_ff[8:0];
            rsp_in.char_value       = (req_ff.char_index < len_rd_ff) ? ws_rd_ff : 8'd0;
         end
      end
   end

   // Memory ports.
   always_ff @(posedge clock) begin
      if (cmd.code == CMD_APPEND && run_len_ff < RUN_CW'(MAX_WORD_BYTES)) begin
         rb_mem[run_len_ff[RUN_W-1:0]] <= req_ff.text_byte;
      end
      if (cmd.code == CMD_RD_BYTE || cmd.code == CMD_RD_RUN) begin
         rb_rd_ff <= rb_mem[k_ff];
      end
      if (cmd.code == CMD_WR_WORD) begin
         ws_mem[ws_waddr] <= rb_rd_ff;
      end
      if (cmd.code == CMD_RD_BYTE || cmd.code == CMD_RD_ENT) begin
         ws_rd_ff <= ws_mem[ws_raddr];
      end
      if (cmd.code == CMD_NEW_ENTRY) begin
         len_mem[slot_ff] <= run_len_ff[7:0];
      end
      if (cmd.code == CMD_RD_LEN || cmd.code == CMD_RD_ENT) begin
         len_rd_ff <= len_mem[ent_idx];
      end
      if (cmd.code == CMD_NEW_ENTRY) begin
         cnt_mem[slot_ff] <= 32'd1;
      end else if (cmd.code == CMD_CNT_UPD && cnt_rd_ff != 32'hFFFF_FFFF) begin
         cnt_mem[slot_ff] <= cnt_rd_ff + 32'd1;
      end
      if (cmd.code == CMD_RD_CNT) begin
         cnt_rd_ff <= cnt_mem[slot_ff];
      end else if (cmd.code == CMD_RD_ENT) begin
         cnt_rd_ff <= cnt_mem[ent_idx];
      end
      if (cmd.code == CMD_NEW_ENTRY) begin
         ref_mem[slot_ff] <= '0;
      end else if (cmd.code == CMD_REF_WR) begin
         ref_mem[ent_idx] <= qualify ? {1'b1, next_ff} : 11'd0;
      end
      if (cmd.code == CMD_RD_ENT) begin
         ref_rd_ff <= ref_mem[ent_idx];
      end
   end

   // Working registers and gain pipeline.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      case (cmd.code)
         CMD_ENT_CLR:    ent_ff <= '0;
         CMD_ENT_INC:    ent_ff <= ent_ff + ENT_CW'(1);
         CMD_K_CLR:      k_ff <= '0;
         CMD_K_INC:      k_ff <= k_ff + RUN_W'(1);
         CMD_SLOT_FOUND: slot_ff <= ent_idx;
         CMD_SLOT_NEW: begin
            slot_ff <= stored_ff[ENT_W-1:0];
            k_ff    <= '0;
         end
         CMD_WR_WORD:    k_ff <= k_ff + RUN_W'(1);
         CMD_FIN_INIT: begin
            ent_ff  <= '0;
            next_ff <= '0;
         end
         CMD_ENT_LOAD: begin
            ent_ff <= ENT_CW'(req_ff.entry_index);
            k_ff   <= req_ff.char_index;
         end
         CMD_GAIN1:      bw_ff <= BW_W'({5'b0, len_rd_ff} * {8'b0, bpc_ff});
         CMD_GAIN2: begin
            rep_ff  <= {13'b0, cnt_rd_ff} * {32'b0, bw_ff};
            kept_ff <= ((refw_ff == 2'd2) ? {2'b0, cnt_rd_ff, 4'b0} : {3'b0, cnt_rd_ff, 3'b0})
                       + {25'b0, bw_ff} + KEPT_W'(OVERHEAD_BITS);
         end
         CMD_GAIN3: begin
            if (diff[GAIN_W]) begin
               gain_ff <= diff[GAIN_W-1:0];
            end else if (diff[GAIN_W-1]) begin
               gain_ff <= GAIN_MAX;
            end else begin
               gain_ff <= diff[GAIN_W-1:0];
            end
            gain_pos_ff <= !diff[GAIN_W] && (diff != '0);
         end
         CMD_REF_WR: begin
            if (qualify) next_ff <= next_ff + 10'd1;
            ent_ff <= ent_ff + ENT_CW'(1);
         end
         default: begin
         end
      endcase
      if (cmd.code == CMD_LOAD_RSP) begin
         rsp_ff <= rsp_in;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff   <= '0;
         too_long_ff  <= 1'b0;
         stored_ff    <= '0;
         err_ff       <= ST_OK;
         refw_ff      <= 2'd1;
         done_ff      <= 1'b0;
         bpc_ff       <= 5'd8;
         minlen_ff    <= 8'd3;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BITS_PER_CHAR: bpc_ff    <= csr_wdata[4:0];
               CSR_MIN_WORD_LEN:  minlen_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         case (cmd.code)
            CMD_CLEAR: begin
               if (done_ff) begin
                  run_len_ff  <= '0;
                  too_long_ff <= 1'b0;
                  stored_ff   <= '0;
                  err_ff      <= ST_OK;
                  refw_ff     <= 2'd1;
                  done_ff     <= 1'b0;
               end
            end
            CMD_APPEND: begin
               if (run_len_ff < RUN_CW'(MAX_WORD_BYTES)) begin
                  run_len_ff <= run_len_ff + RUN_CW'(1);
               end else begin
                  too_long_ff <= 1'b1;
               end
            end
            CMD_SET_FULL:  err_ff <= ST_TABLE_FULL;
            CMD_NEW_ENTRY: stored_ff <= stored_ff + ENT_CW'(1);
            CMD_CNT_UPD: begin
               if (cnt_rd_ff == 32'hFFFF_FFFF) err_ff <= ST_COUNT_OVF;
            end
            CMD_RUN_CLR: begin
               run_len_ff  <= '0;
               too_long_ff <= 1'b0;
            end
            CMD_FIN_INIT: refw_ff <= (stored_ff > ENT_CW'(REF_THRESHOLD)) ? 2'd2 : 2'd1;
            CMD_SET_DONE: done_ff <= 1'b1;
            default: begin
            end
         endcase
         if (cmd.code == CMD_LOAD_RSP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

[rtl/word_dictionary_trainer.sv]
// ----------------------------------------------------------------------------
// Word dictionary trainer
// A read result is loaded after the entry read and the gain steps; a finish
// result closes any open run, then walks every stored entry through them.
// One word is in work at a time and the input is ready only in idle; a text
// byte that extends a run frees it soonest, a word end also compares and
// copies bytes. Reset is synchronous and active high; it empties the table and
// sets bits per char to 8 and the minimum length to 3. Memories are not cleared.
// ----------------------------------------------------------------------------
module word_dictionary_trainer import wdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // The controller steps through the lookup, insert, finish and read
   // sequences, and the datapath holds all memories and arithmetic. They talk
   // through the command code, the status bundle below and the input ready.
   cmd_type       cmd;
   dp_status_type st;

   wdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // The result register in the datapath lets a finished word wait for the
   // consumer while the controller returns to idle and takes the next word.
   wdt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .st        (st)
   );

endmodule

[rtl/wdt_checker.sv]
// ----------------------------------------------------------------------------
// Word dictionary trainer checker
// Port level checks, attached to the top level by a bind.
// ----------------------------------------------------------------------------
module wdt_checker import wdt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input rsp_type    rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.ref_width_bytes == 2'd1 || rsp_data.ref_width_bytes == 2'd2))
      else $error("bad reference width");

   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_total <= 10'(MAX_ENTRIES))
      else $error("entry total beyond table size");

   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_BAD_INDEX |->
         rsp_data.word_length == 8'd0 && rsp_data.occurrence_count == 32'd0 &&
         rsp_data.has_ref == 1'b0)
      else $error("entry fields set on bad index");

endmodule

bind word_dictionary_trainer wdt_checker u_wdt_checker (.*);
